// ===== src/pblc_pkg.sv =====
// Shared types and codes for the palette buffer load control block.
package pblc_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned BASE_W  = 14;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned LOADS_W = 16;

  localparam logic [1:0] OP_SETUP = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] LC_KEEP  = 3'd0;
  localparam logic [2:0] LC_SAVE0 = 3'd2;
  localparam logic [2:0] LC_SAVE1 = 3'd3;
  localparam logic [2:0] LC_CMP0  = 3'd4;
  localparam logic [2:0] LC_CMP1  = 3'd5;
  localparam logic [2:0] LC_ODD6  = 3'd6;

  localparam logic [1:0] PK_16  = 2'd1;
  localparam logic [1:0] PK_256 = 2'd2;

  localparam logic [CNT_W-1:0] ENTRIES_16  = 9'd16;
  localparam logic [CNT_W-1:0] ENTRIES_256 = 9'd256;

  typedef struct packed {
    logic [1:0]        op;
    logic [2:0]        load_code;
    logic [BASE_W-1:0] base_ptr;
    logic [1:0]        palette_kind;
    logic              wide_entries;
    logic              linear_mode;
    logic [4:0]        group_offset;
    logic [PIX_W-1:0]  pixel_value;
    logic [7:0]        word_index;
  } item_t;

  typedef struct packed {
    logic               load_started;
    logic [CNT_W-1:0]   entry_count;
    logic               unlisted_code;
    logic               load_done;
    logic [LOADS_W-1:0] loads_completed;
  } res_t;

  typedef struct packed {
    logic we;
    logic full;
    logic hi_half;
  } wr_ctl_t;

endpackage

// ===== src/palette_buffer_load_control_unit.sv =====
// Palette buffer load control: a 1 KB palette buffer loaded under texture-setup control.
//
// Input transactions carry the item kind on in_tuser: texture setup, fetched palette
// value, or buffer read. Every input transaction yields exactly one result transaction.
// A setup applies its load-control code, may save the base pointer, and may start a
// 16- or 256-entry load; later value transactions fill the buffer in entry order.
// A read transaction returns one buffer word in the result.
//
// An item passes one input register, then the result register, which also holds the
// buffer read data. The block accepts one transaction per cycle; each transaction
// makes at most one buffer write or one buffer read. When the receiver stalls, the
// result register holds, and once the input register is also occupied in_tready
// drops, so at most two transactions wait inside the block.
//
// Reset clears the saved bases, the pending load, the load counter and the valid bit
// of every buffer row, so the whole buffer reads as zero immediately after reset.
module palette_buffer_load_control_unit import pblc_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // load_code[2:0], base_ptr[16:3], palette_kind[18:17], wide_entries[19],
  // linear_mode[20], group_offset[25:21], pixel_value[57:26], word_index[65:58]
  input  logic [71:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // load_started[0], entry_count[9:1], unlisted_code[10], load_done[11],
  // read_word[43:12], loads_completed[59:44]
  output logic [63:0] out_tdata
);

  localparam int unsigned AW = $clog2(BUFFER_WORDS);

  item_t            s1_item_r;
  logic             s1_valid_r;
  res_t             out_res_r;
  logic             out_is_rd_r;
  logic             out_valid_r;
  logic             go;
  item_t            in_item;
  res_t             res;
  wr_ctl_t          wr_ctl;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] rd_word;

  assign in_item.op           = in_tuser;
  assign in_item.load_code    = in_tdata[2:0];
  assign in_item.base_ptr     = in_tdata[16:3];
  assign in_item.palette_kind = in_tdata[18:17];
  assign in_item.wide_entries = in_tdata[19];
  assign in_item.linear_mode  = in_tdata[20];
  assign in_item.group_offset = in_tdata[25:21];
  assign in_item.pixel_value  = in_tdata[57:26];
  assign in_item.word_index   = in_tdata[65:58];

  assign go        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (go) begin
      out_res_r   <= res;
      out_is_rd_r <= (s1_item_r.op == OP_READ);
    end
  end

  pblc_ctrl #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (s1_item_r),
    .res     (res),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr)
  );

  pblc_palette_ram #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_data (s1_item_r.pixel_value),
    .rd_en   (go && s1_item_r.op == OP_READ),
    .rd_addr (s1_item_r.word_index[AW-1:0]),
    .rd_word (rd_word)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0,
                       out_res_r.loads_completed,
                       out_is_rd_r ? rd_word : {PIX_W{1'b0}},
                       out_res_r.load_done,
                       out_res_r.unlisted_code,
                       out_res_r.entry_count,
                       out_res_r.load_started};

endmodule

// ===== src/pblc_palette_ram.sv =====
// Palette buffer memory with per-row valid bits; invalid rows read as zero.
module pblc_palette_ram import pblc_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = 256,
  localparam int unsigned AW = $clog2(BUFFER_WORDS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_ctl_t          wr_ctl,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_word
);

  logic [PIX_W-1:0]        mem [BUFFER_WORDS];
  logic [BUFFER_WORDS-1:0] row_valid_r;
  logic [PIX_W-1:0]        rd_data_r;
  logic                    rd_ok_r;

  // A half-word write to a row never written fills the other half with zero.
  always_ff @(posedge clk) begin
    if (wr_ctl.we) begin
      if (wr_ctl.full) begin
        mem[wr_addr] <= wr_data;
      end else if (!row_valid_r[wr_addr]) begin
        mem[wr_addr] <= wr_ctl.hi_half ? {wr_data[15:0], 16'h0000} : {16'h0000, wr_data[15:0]};
      end else if (wr_ctl.hi_half) begin
        mem[wr_addr][31:16] <= wr_data[15:0];
      end else begin
        mem[wr_addr][15:0] <= wr_data[15:0];
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_ok_r     <= 1'b0;
    end else begin
      if (wr_ctl.we) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= row_valid_r[rd_addr];
      end
    end
  end

  assign rd_word = rd_ok_r ? rd_data_r : '0;

endmodule

// ===== src/pblc_ctrl.sv =====
// Load control: saved bases, pending load tracking and buffer write generation.
module pblc_ctrl import pblc_pkg::*; #(
  parameter int unsigned BUFFER_WORDS = 256,
  localparam int unsigned AW = $clog2(BUFFER_WORDS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  item_t         item,
  output res_t          res,
  output wr_ctl_t       wr_ctl,
  output logic [AW-1:0] wr_addr
);

  logic [BASE_W-1:0]  saved_base0_r, saved_base0_nxt;
  logic [BASE_W-1:0]  saved_base1_r, saved_base1_nxt;
  logic [CNT_W-1:0]   remaining_r, remaining_nxt;
  logic [AW:0]        next_entry_r, next_entry_nxt;
  logic               pending_wide_r, pending_wide_nxt;
  logic [LOADS_W-1:0] load_count_r, load_count_nxt;
  logic               want;
  logic [CNT_W-1:0]   count;

  always_comb begin
    saved_base0_nxt  = saved_base0_r;
    saved_base1_nxt  = saved_base1_r;
    remaining_nxt    = remaining_r;
    next_entry_nxt   = next_entry_r;
    pending_wide_nxt = pending_wide_r;
    load_count_nxt   = load_count_r;
    res              = '0;
    wr_ctl           = '0;
    want             = 1'b0;
    count            = '0;
    wr_addr          = pending_wide_r ? next_entry_r[AW-1:0] : next_entry_r[AW:1];

    unique case (item.op)
      OP_SETUP: begin
        // Codes 4 and 5 compare against the slot as it stood before this item.
        priority if (item.load_code == LC_KEEP) begin
          want = 1'b0;
        end else if (item.load_code == LC_CMP0) begin
          want = (item.base_ptr != saved_base0_r);
        end else if (item.load_code == LC_CMP1) begin
          want = (item.base_ptr != saved_base1_r);
        end else begin
          want = 1'b1;
        end
        if (item.load_code == LC_SAVE0 || item.load_code == LC_CMP0) begin
          saved_base0_nxt = item.base_ptr;
        end
        if (item.load_code == LC_SAVE1 || item.load_code == LC_CMP1) begin
          saved_base1_nxt = item.base_ptr;
        end
        if (item.palette_kind == PK_16) begin
          count = ENTRIES_16;
        end else if (item.palette_kind == PK_256) begin
          count = ENTRIES_256;
        end
        res.unlisted_code = (item.load_code >= LC_ODD6);
        remaining_nxt     = '0;
        if (want && count != '0) begin
          res.load_started = 1'b1;
          res.entry_count  = count;
          remaining_nxt    = count;
          pending_wide_nxt = item.wide_entries;
          next_entry_nxt   = (item.palette_kind == PK_16) ? {item.group_offset, 4'b0000} : '0;
        end
      end
      OP_VALUE: begin
        if (remaining_r != '0) begin
          wr_ctl.we      = 1'b1;
          wr_ctl.full    = pending_wide_r;
          wr_ctl.hi_half = next_entry_r[0];
          next_entry_nxt = next_entry_r + 1'b1;
          remaining_nxt  = remaining_r - 1'b1;
          if (remaining_r == CNT_W'(1)) begin
            res.load_done  = 1'b1;
            load_count_nxt = load_count_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.loads_completed = load_count_nxt;
    wr_ctl.we = wr_ctl.we & go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_base0_r  <= '0;
      saved_base1_r  <= '0;
      remaining_r    <= '0;
      next_entry_r   <= '0;
      pending_wide_r <= 1'b0;
      load_count_r   <= '0;
    end else if (go) begin
      saved_base0_r  <= saved_base0_nxt;
      saved_base1_r  <= saved_base1_nxt;
      remaining_r    <= remaining_nxt;
      next_entry_r   <= next_entry_nxt;
      pending_wide_r <= pending_wide_nxt;
      load_count_r   <= load_count_nxt;
    end
  end

endmodule
